// ===== src/lbo_pkg.sv =====
// Shared constants for the line/box overlap pipeline.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lbo_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DIV_STEPS     = 32;
  // prep + quotient bits + sign/saturate
  localparam int DIV_LAT       = DIV_STEPS + 2;
  localparam int PROJ_LAT      = 2;
  localparam int CFG_IDX_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EPS       = 3'd6;
endpackage
`default_nettype wire

// ===== src/line_box_overlap_test.sv =====
// Top level of the line/box overlap pipeline.
// Uses lbo_pkg, lbo_div, lbo_proj.
//
// Tests an infinite line (origin, direction, signed fixed point) against the
// configured axis-aligned box and returns one hit flag per request. Fully
// pipelined: one request per cycle while not stalled; the dividers are
// 32-stage bit-per-stage (six in parallel), followed by the projection
// stages and the output register. The whole pipe stalls while a result is
// held with output ready low. Write the box only while idle.
`timescale 1ns / 1ps
`default_nettype none
module line_box_overlap_test #(
  parameter int FRAC_BITS = lbo_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [lbo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [31:0]                         cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [31:0]                  in_origin_x,
  input  wire logic signed [31:0]                  in_origin_y,
  input  wire logic signed [31:0]                  in_origin_z,
  input  wire logic signed [31:0]                  in_dir_x,
  input  wire logic signed [31:0]                  in_dir_y,
  input  wire logic signed [31:0]                  in_dir_z,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_hit
);
  localparam int DL = lbo_pkg::DIV_LAT;
  localparam int L  = DL + lbo_pkg::PROJ_LAT;

  logic signed [31:0] box_lo_r [0:2];
  logic signed [31:0] box_hi_r [0:2];
  logic [30:0]        eps_r;

  logic               v_r  [0:L-1];
  logic [2:0]         td_r [0:L-1];
  logic signed [31:0] od_r [0:DL-1][0:2];
  logic signed [31:0] ud_r [0:DL-1][0:2];
  logic               out_valid_r, out_hit_r;
  logic               adv;

  logic signed [31:0] org [0:2];
  logic signed [31:0] dir [0:2];
  logic [2:0]         tested;
  logic signed [31:0] t1 [0:2];
  logic signed [31:0] t2 [0:2];
  logic               rej [0:2][0:1];
  logic               hit_nxt;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign org[0] = in_origin_x;
  assign org[1] = in_origin_y;
  assign org[2] = in_origin_z;
  assign dir[0] = in_dir_x;
  assign dir[1] = in_dir_y;
  assign dir[2] = in_dir_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        box_lo_r[k] <= '0;
        box_hi_r[k] <= '0;
      end
      eps_r <= 31'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lbo_pkg::REG_BOX_MIN_X: box_lo_r[0] <= cfg_data;
        lbo_pkg::REG_BOX_MIN_Y: box_lo_r[1] <= cfg_data;
        lbo_pkg::REG_BOX_MIN_Z: box_lo_r[2] <= cfg_data;
        lbo_pkg::REG_BOX_MAX_X: box_hi_r[0] <= cfg_data;
        lbo_pkg::REG_BOX_MAX_Y: box_hi_r[1] <= cfg_data;
        lbo_pkg::REG_BOX_MAX_Z: box_hi_r[2] <= cfg_data;
        lbo_pkg::REG_EPS:       eps_r       <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic [32:0] mag;
    assign mag       = dir[i][31] ? 33'(-33'(dir[i])) : 33'(dir[i]);
    assign tested[i] = mag > 33'(eps_r);

    lbo_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
      .clk(clk), .en(adv),
      .num_i(33'(box_hi_r[i]) - 33'(org[i])),
      .den_i(dir[i]), .q_o(t1[i])
    );
    lbo_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
      .clk(clk), .en(adv),
      .num_i(33'(box_lo_r[i]) - 33'(org[i])),
      .den_i(dir[i]), .q_o(t2[i])
    );

    for (genvar n = 0; n < 2; n++) begin : g_other
      localparam int J = (i + n + 1) % 3;
      lbo_proj #(.FRAC_BITS(FRAC_BITS)) u_proj (
        .clk(clk), .en(adv),
        .t1_i(t1[i]), .t2_i(t2[i]),
        .dir_i(ud_r[DL-1][J]), .org_i(od_r[DL-1][J]),
        .box_lo_i(box_lo_r[J]), .box_hi_i(box_hi_r[J]),
        .reject_o(rej[i][n])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < L; k++) v_r[k] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
      for (int k = 1; k < L; k++) v_r[k] <= v_r[k-1];
      out_valid_r <= v_r[L-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      td_r[0] <= tested;
      for (int k = 1; k < L; k++) td_r[k] <= td_r[k-1];
      for (int a = 0; a < 3; a++) begin
        od_r[0][a] <= org[a];
        ud_r[0][a] <= dir[a];
      end
      for (int k = 1; k < DL; k++) begin
        od_r[k] <= od_r[k-1];
        ud_r[k] <= ud_r[k-1];
      end
      out_hit_r <= hit_nxt;
    end
  end

  always_comb begin
    hit_nxt = 1'b1;
    for (int a = 0; a < 3; a++)
      if (td_r[L-1][a] && (rej[a][0] || rej[a][1])) hit_nxt = 1'b0;
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

  // no axis tested: must hit
  a_untested_hits: assert property (@(posedge clk) disable iff (!rst_n)
    adv && v_r[L-1] && td_r[L-1] == 3'b000 |=> out_hit_r)
    else $error("untested line reported miss");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v_r[L-1]))
    else $error("result without request in last stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v_r[L-1]) && $stable(td_r[L-1]))
    else $error("pipeline moved during stall");
endmodule
`default_nettype wire

// ===== src/lbo_div.sv =====
// Pipelined saturating fixed-point divider: (num << FRAC_BITS) / den.
// One quotient bit per stage. Uses lbo_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lbo_div #(
  parameter int FRAC_BITS = lbo_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [32:0] num_i,
  input  wire logic signed [31:0] den_i,
  output logic signed [31:0]      q_o
);
  localparam int NW = 33 + FRAC_BITS;
  localparam int HW = NW - 32;
  localparam int ST = lbo_pkg::DIV_STEPS;

  logic signed [NW-1:0] nsh;
  logic [NW-1:0]        nabs;
  logic [31:0]          dabs;
  logic [HW-1:0]        nhi;

  logic [31:0] rem_r [0:ST];
  logic [31:0] lo_r  [0:ST];
  logic [31:0] q_r   [0:ST];
  logic [31:0] den_r [0:ST];
  logic        neg_r [0:ST];
  logic        ovf_r [0:ST];
  logic signed [31:0] q_out_r;

  always_comb begin
    nsh  = {num_i, {FRAC_BITS{1'b0}}};
    nabs = nsh[NW-1] ? NW'(-nsh) : NW'(nsh);
    dabs = den_i[31] ? 32'(-den_i) : 32'(den_i);
    nhi  = nabs[NW-1:32];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= 32'(nhi);
      lo_r[0]  <= nabs[31:0];
      q_r[0]   <= '0;
      den_r[0] <= dabs;
      neg_r[0] <= num_i[32] ^ den_i[31];
      ovf_r[0] <= 32'(nhi) >= dabs;
    end
  end

  for (genvar k = 0; k < ST; k++) begin : g_step
    logic [32:0] tr;
    logic        ge;
    always_comb begin
      tr = {rem_r[k], lo_r[k][31]};
      ge = tr >= {1'b0, den_r[k]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? 32'(tr - {1'b0, den_r[k]}) : tr[31:0];
        lo_r[k+1]  <= {lo_r[k][30:0], 1'b0};
        q_r[k+1]   <= {q_r[k][30:0], ge};
        den_r[k+1] <= den_r[k];
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_r[ST]) begin
        if (ovf_r[ST] || q_r[ST] > 32'h8000_0000) q_out_r <= 32'sh8000_0000;
        else                                     q_out_r <= 32'(-q_r[ST]);
      end else begin
        if (ovf_r[ST] || q_r[ST][31]) q_out_r <= 32'sh7fff_ffff;
        else                          q_out_r <= q_r[ST];
      end
    end
  end

  assign q_o = q_out_r;
endmodule
`default_nettype wire

// ===== src/lbo_proj.sv =====
// Projects the two plane hits onto one other axis and tests the span.
// Multiply stage then add/compare stage. Uses lbo_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lbo_proj #(
  parameter int FRAC_BITS = lbo_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [31:0] t1_i,
  input  wire logic signed [31:0] t2_i,
  input  wire logic signed [31:0] dir_i,
  input  wire logic signed [31:0] org_i,
  input  wire logic signed [31:0] box_lo_i,
  input  wire logic signed [31:0] box_hi_i,
  output logic                    reject_o
);
  logic signed [63:0] pr1_r, pr2_r;
  logic signed [31:0] org_r;
  logic signed [63:0] p1, p2, blo, bhi;
  logic               reject_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pr1_r <= dir_i * t1_i;
      pr2_r <= dir_i * t2_i;
      org_r <= org_i;
    end
  end

  always_comb begin
    p1  = 64'(org_r) + (pr1_r >>> FRAC_BITS);
    p2  = 64'(org_r) + (pr2_r >>> FRAC_BITS);
    blo = 64'(box_lo_i);
    bhi = 64'(box_hi_i);
  end

  always_ff @(posedge clk) begin
    if (en) reject_r <= (p1 > bhi && p2 > bhi) || (p1 < blo && p2 < blo);
  end

  assign reject_o = reject_r;
endmodule
`default_nettype wire
